@@ design/bobc_pkg.sv @@
// Shared constants, types and format functions of the block offset bit-pack compressor.
package bobc_pkg;

   localparam int BLOCK_LEN       = 16;
   localparam int FILL_W          = $clog2(BLOCK_LEN);
   localparam int RUN_STORE_DEPTH = 512;
   localparam int ADDR_W          = $clog2(RUN_STORE_DEPTH);
   localparam int USED_W          = ADDR_W + 1;
   localparam int SAMPLE_W        = 31;
   localparam int WIDTH_W         = 5;
   localparam int BLOCKS_W        = 6;
   localparam int HI_W            = SAMPLE_W - 4;
   localparam int ACC_W           = SAMPLE_W + 7;
   localparam int NACC_W          = 6;
   localparam int TOTAL_W         = BLOCKS_W + FILL_W;
   localparam int CMD_DEPTH       = 4;
   localparam int CMD_PTR_W       = $clog2(CMD_DEPTH);
   localparam int OUT_DEPTH       = 4;
   localparam int OUT_PTR_W       = $clog2(OUT_DEPTH);

   localparam logic [7:0] START_BYTE = 8'(BLOCK_LEN);
   localparam logic [7:0] MIN_FLAG   = 8'h80;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_RUN,
      CMD_END
   } cmd_kind_type;

   typedef enum logic [1:0] {
      TAG_ZERO,
      TAG_NARROW,
      TAG_MID,
      TAG_WIDE
   } tag_type;

   typedef enum logic [2:0] {
      FS_IDLE,
      FS_START,
      FS_DIFF,
      FS_WIDTH,
      FS_DECIDE,
      FS_FIN,
      FS_END
   } front_state_type;

   typedef enum logic [3:0] {
      BS_IDLE,
      BS_START,
      BS_HEAD,
      BS_MIN0,
      BS_MINX,
      BS_READ,
      BS_SUB,
      BS_MERGE,
      BS_EMIT,
      BS_PAD,
      BS_FREE,
      BS_FLUSH
   } back_state_type;

   typedef struct packed {
      cmd_kind_type               kind;
      logic signed [SAMPLE_W-1:0] minimum;
      logic [WIDTH_W-1:0]         width;
      logic [BLOCKS_W-1:0]        blocks;
      logic [ADDR_W-1:0]          base;
   } cmd_type;

   typedef struct packed {
      logic              valid;
      logic [USED_W-1:0] count;
   } free_type;

   typedef struct packed {
      logic [31:0] bytes;
      logic [2:0]  count;
      logic        last;
   } word_type;

   function automatic logic [WIDTH_W-1:0] bit_length(input logic [SAMPLE_W-1:0] d);
      logic [WIDTH_W-1:0] w;
      w = '0;
      for (int i = 0; i < SAMPLE_W; i++) begin
         if (d[i]) w = WIDTH_W'(i + 1);
      end
      return w;
   endfunction

   function automatic tag_type tag_of(input logic [WIDTH_W-1:0] w);
      tag_type t;
      if (w == '0) t = TAG_ZERO;
      else if (w <= WIDTH_W'(2)) t = TAG_NARROW;
      else if (w <= WIDTH_W'(6)) t = TAG_MID;
      else t = TAG_WIDE;
      return t;
   endfunction

   function automatic logic [BLOCKS_W-1:0] run_limit(input logic [WIDTH_W-1:0] w);
      logic [BLOCKS_W-1:0] lim;
      case (tag_of(w))
         TAG_ZERO:   lim = BLOCKS_W'(32);
         TAG_NARROW: lim = BLOCKS_W'(16);
         TAG_MID:    lim = BLOCKS_W'(8);
         default:    lim = BLOCKS_W'(1);
      endcase
      return lim;
   endfunction

   function automatic logic [7:0] header_byte(input logic [WIDTH_W-1:0] w,
                                              input logic [BLOCKS_W-1:0] blocks);
      logic [7:0] cnt;
      logic [7:0] wv;
      logic [7:0] h;
      cnt = 8'(blocks - BLOCKS_W'(1));
      wv  = 8'(w);
      case (tag_of(w))
         TAG_ZERO:   h = cnt << 2;
         TAG_NARROW: h = 8'(TAG_NARROW) + (cnt << 2) + ((wv - 8'd1) << 6);
         TAG_MID:    h = 8'(TAG_MID) + (cnt << 2) + ((wv - 8'd3) << 5);
         default:    h = 8'(TAG_WIDE) + ((wv - 8'd1) << 2);
      endcase
      return h;
   endfunction

endpackage

@@ design/bobc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module bobc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ design/bobc_cmd_queue.sv @@
// Short command queue between the classifying front and the emitting back.
module bobc_cmd_queue import bobc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   cmd_type                entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wptr_ff, wptr_in;
   logic [CMD_PTR_W-1:0]   rptr_ff, rptr_in;
   logic [CMD_PTR_W:0]     count_ff, count_in;
   logic                   do_push, do_pop;

   assign full     = (count_ff == (CMD_PTR_W+1)'(CMD_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = do_push ? wptr_ff + CMD_PTR_W'(1) : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + CMD_PTR_W'(1) : rptr_ff;
      count_in = count_ff + (CMD_PTR_W+1)'(do_push) - (CMD_PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) entry_ff[wptr_ff] <= push_data;
   end

endmodule

@@ design/bobc_front.sv @@
// Front: takes samples into the ring store, tracks blocks and runs, queues emit commands.
module bobc_front import bobc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_final_sample,
   output logic                       ram_we,
   output logic [ADDR_W-1:0]          ram_waddr,
   output logic [SAMPLE_W-1:0]        ram_wdata,
   output logic                       cmd_push,
   output cmd_type                    cmd_data,
   input  logic                       cmd_full,
   input  free_type                   free
);

   front_state_type            state_ff, state_in;
   logic [ADDR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [USED_W-1:0]          used_ff, used_in;
   logic [FILL_W-1:0]          fill_ff, fill_in;
   logic signed [SAMPLE_W-1:0] blk_min_ff, blk_min_in;
   logic signed [SAMPLE_W-1:0] blk_max_ff, blk_max_in;
   logic [SAMPLE_W-1:0]        diff_ff, diff_in;
   logic [WIDTH_W-1:0]         width_ff, width_in;
   logic signed [SAMPLE_W-1:0] run_min_ff, run_min_in;
   logic [WIDTH_W-1:0]         run_width_ff, run_width_in;
   logic [BLOCKS_W-1:0]        run_blocks_ff, run_blocks_in;
   logic [ADDR_W-1:0]          run_base_ff, run_base_in;
   logic                       run_open_ff, run_open_in;
   logic                       started_ff, started_in;
   logic                       fin_ff, fin_in;
   logic                       blk_end_ff, blk_end_in;
   logic                       pushed_ff, pushed_in;

   logic                       accept;
   logic                       join_run;
   logic                       inc;
   logic [USED_W-1:0]          rewind;
   logic [USED_W-1:0]          freed;
   logic signed [SAMPLE_W:0]   span;
   cmd_type                    run_cmd;

   assign req_full = (state_ff != FS_IDLE) || (used_ff == USED_W'(RUN_STORE_DEPTH));
   assign accept   = req_push && !req_full;
   assign join_run = run_open_ff && (width_ff == run_width_ff) &&
                     (blk_min_ff == run_min_ff) && (run_blocks_ff < run_limit(width_ff));
   assign span     = {blk_max_ff[SAMPLE_W-1], blk_max_ff} - {blk_min_ff[SAMPLE_W-1], blk_min_ff};
   assign freed    = free.valid ? free.count : '0;

   always_comb begin
      run_cmd         = '0;
      run_cmd.kind    = CMD_RUN;
      run_cmd.minimum = run_min_ff;
      run_cmd.width   = run_width_ff;
      run_cmd.blocks  = run_blocks_ff;
      run_cmd.base    = run_base_ff;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FS_IDLE: begin
            if (accept) begin
               if (!started_ff) state_in = FS_START;
               else if (fill_ff == FILL_W'(BLOCK_LEN - 1)) state_in = FS_DIFF;
               else if (req_final_sample) state_in = FS_FIN;
            end
         end
         FS_START: begin
            if (started_ff || !cmd_full) begin
               if (blk_end_ff) state_in = FS_DIFF;
               else if (fin_ff) state_in = FS_FIN;
               else state_in = FS_END;
            end
         end
         FS_DIFF:  state_in = FS_WIDTH;
         FS_WIDTH: state_in = FS_DECIDE;
         FS_DECIDE: begin
            if (join_run || !run_open_ff || !cmd_full) begin
               if (fin_ff) state_in = FS_FIN;
               else if (pushed_ff || (!join_run && run_open_ff)) state_in = FS_END;
               else state_in = FS_IDLE;
            end
         end
         FS_FIN: begin
            if (!run_open_ff || !cmd_full) begin
               if (pushed_ff || run_open_ff) state_in = FS_END;
               else state_in = FS_IDLE;
            end
         end
         FS_END: begin
            if (!cmd_full) state_in = FS_IDLE;
         end
         default: state_in = FS_IDLE;
      endcase
   end

   always_comb begin
      fill_in       = fill_ff;
      blk_min_in    = blk_min_ff;
      blk_max_in    = blk_max_ff;
      diff_in       = diff_ff;
      width_in      = width_ff;
      run_min_in    = run_min_ff;
      run_width_in  = run_width_ff;
      run_blocks_in = run_blocks_ff;
      run_base_in   = run_base_ff;
      run_open_in   = run_open_ff;
      started_in    = started_ff;
      fin_in        = fin_ff;
      blk_end_in    = blk_end_ff;
      pushed_in     = pushed_ff;
      ram_we        = 1'b0;
      ram_waddr     = wr_ptr_ff;
      ram_wdata     = req_sample;
      cmd_push      = 1'b0;
      cmd_data      = run_cmd;
      inc           = 1'b0;
      rewind        = '0;
      case (state_ff)
         FS_IDLE: begin
            if (accept) begin
               ram_we     = 1'b1;
               inc        = 1'b1;
               fill_in    = fill_ff + FILL_W'(1);
               fin_in     = req_final_sample;
               blk_end_in = (fill_ff == FILL_W'(BLOCK_LEN - 1));
               pushed_in  = 1'b0;
               if (fill_ff == '0) begin
                  blk_min_in = req_sample;
                  blk_max_in = req_sample;
               end else begin
                  if (req_sample < blk_min_ff) blk_min_in = req_sample;
                  if (req_sample > blk_max_ff) blk_max_in = req_sample;
               end
            end
         end
         FS_START: begin
            if (!started_ff && !cmd_full) begin
               cmd_push      = 1'b1;
               cmd_data.kind = CMD_START;
               started_in    = 1'b1;
               pushed_in     = 1'b1;
            end
         end
         FS_DIFF:  diff_in  = span[SAMPLE_W-1:0];
         FS_WIDTH: width_in = bit_length(diff_ff);
         FS_DECIDE: begin
            if (join_run) begin
               run_blocks_in = run_blocks_ff + BLOCKS_W'(1);
               if (width_ff == '0) rewind = USED_W'(BLOCK_LEN);
            end else if (!run_open_ff || !cmd_full) begin
               if (run_open_ff) begin
                  cmd_push  = 1'b1;
                  pushed_in = 1'b1;
               end
               run_open_in   = 1'b1;
               run_min_in    = blk_min_ff;
               run_width_in  = width_ff;
               run_blocks_in = BLOCKS_W'(1);
               run_base_in   = wr_ptr_ff - ADDR_W'(BLOCK_LEN);
               if (width_ff == '0) rewind = USED_W'(BLOCK_LEN);
            end
         end
         FS_FIN: begin
            if (!run_open_ff || !cmd_full) begin
               if (run_open_ff) begin
                  cmd_push  = 1'b1;
                  pushed_in = 1'b1;
               end
               // The incomplete block is dropped, so its samples leave the ring.
               rewind        = USED_W'(fill_ff);
               run_open_in   = 1'b0;
               run_blocks_in = '0;
               fill_in       = '0;
               started_in    = 1'b0;
            end
         end
         FS_END: begin
            if (!cmd_full) begin
               cmd_push      = 1'b1;
               cmd_data.kind = CMD_END;
            end
         end
         default: begin
         end
      endcase
      wr_ptr_in = wr_ptr_ff + ADDR_W'(inc) - rewind[ADDR_W-1:0];
      used_in   = used_ff + USED_W'(inc) - rewind - freed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FS_IDLE;
         wr_ptr_ff     <= '0;
         used_ff       <= '0;
         fill_ff       <= '0;
         run_open_ff   <= 1'b0;
         run_blocks_ff <= '0;
         started_ff    <= 1'b0;
         pushed_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wr_ptr_ff     <= wr_ptr_in;
         used_ff       <= used_in;
         fill_ff       <= fill_in;
         run_open_ff   <= run_open_in;
         run_blocks_ff <= run_blocks_in;
         started_ff    <= started_in;
         pushed_ff     <= pushed_in;
      end
      blk_min_ff   <= blk_min_in;
      blk_max_ff   <= blk_max_in;
      diff_ff      <= diff_in;
      width_ff     <= width_in;
      run_min_ff   <= run_min_in;
      run_width_ff <= run_width_in;
      run_base_ff  <= run_base_in;
      fin_ff       <= fin_in;
      blk_end_ff   <= blk_end_in;
   end

endmodule

@@ design/bobc_back.sv @@
// Back: turns commands into stream bytes, packs them into words and queues the words.
module bobc_back import bobc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_empty,
   input  cmd_type             cmd_data,
   output logic                cmd_pop,
   output logic [ADDR_W-1:0]   ram_raddr,
   input  logic [SAMPLE_W-1:0] ram_rdata,
   output free_type            free,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [31:0]         rsp_out_bytes,
   output logic [2:0]          rsp_byte_count,
   output logic                rsp_burst_last
);

   back_state_type        state_ff, state_in;
   cmd_type               cur_ff, cur_in;
   logic                  sign_ff, sign_in;
   logic [3:0]            nib_ff, nib_in;
   logic [HI_W-1:0]       hi_ff, hi_in;
   logic [2:0]            extra_ff, extra_in;
   logic [TOTAL_W-1:0]    idx_ff, idx_in;
   logic [SAMPLE_W-1:0]   resid_ff, resid_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [NACC_W-1:0]     nacc_ff, nacc_in;

   logic [31:0]           word_ff, word_in;
   logic [2:0]            pcnt_ff, pcnt_in;
   word_type              ofifo_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0]  owptr_ff, owptr_in;
   logic [OUT_PTR_W-1:0]  orptr_ff, orptr_in;
   logic [OUT_PTR_W:0]    ocnt_ff, ocnt_in;

   logic                  byte_valid;
   logic [7:0]            byte_data;
   logic                  byte_ready;
   logic                  flush_req;
   logic                  flush_ready;
   logic                  opush;
   word_type              opush_data;
   logic                  opop;
   logic                  ofull;
   logic [1:0]            bpos;
   logic [31:0]           wbase;

   logic [SAMPLE_W-1:0]   cmag;
   logic [HI_W-1:0]       chi;
   logic [2:0]            cextra;
   logic [TOTAL_W-1:0]    total;
   logic [SAMPLE_W-1:0]   mask;
   logic                  min_nz;

   assign total  = {cur_ff.blocks, FILL_W'(0)};
   assign mask   = SAMPLE_W'((32'd1 << cur_ff.width) - 32'd1);
   assign min_nz = (cur_ff.minimum != '0);
   assign cmag   = cmd_data.minimum[SAMPLE_W-1] ? (~cmd_data.minimum + SAMPLE_W'(1))
                                                : cmd_data.minimum;
   assign chi    = cmag[SAMPLE_W-1:4];

   always_comb begin
      if (chi == '0) cextra = 3'd1;
      else if (chi[HI_W-1:8] == '0) cextra = 3'd2;
      else if (chi[HI_W-1:16] == '0) cextra = 3'd3;
      else if (chi[HI_W-1:24] == '0) cextra = 3'd4;
      else cextra = 3'd5;
   end

   assign ram_raddr = cur_ff.base + idx_ff[ADDR_W-1:0];

   // Packer: a full word waits until the next byte or the end of the burst,
   // so the last word of a burst can carry its flag.
   assign ofull       = (ocnt_ff == (OUT_PTR_W+1)'(OUT_DEPTH));
   assign byte_ready  = !((pcnt_ff == 3'd4) && ofull);
   assign flush_ready = (pcnt_ff == '0) || !ofull;
   assign bpos        = (pcnt_ff == 3'd4) ? 2'd0 : pcnt_ff[1:0];
   assign wbase       = ((pcnt_ff == '0) || (pcnt_ff == 3'd4)) ? '0 : word_ff;

   always_comb begin
      word_in    = word_ff;
      pcnt_in    = pcnt_ff;
      opush      = 1'b0;
      opush_data = '0;
      if (byte_valid && byte_ready) begin
         if (pcnt_ff == 3'd4) begin
            opush            = 1'b1;
            opush_data.bytes = word_ff;
            opush_data.count = 3'd4;
            opush_data.last  = 1'b0;
         end
         word_in = wbase | ({byte_data, 24'b0} >> {bpos, 3'b000});
         pcnt_in = 3'(bpos) + 3'd1;
      end else if (flush_req && flush_ready) begin
         if (pcnt_ff != '0) begin
            opush            = 1'b1;
            opush_data.bytes = word_ff;
            opush_data.count = pcnt_ff;
            opush_data.last  = 1'b1;
         end
         pcnt_in = '0;
      end
   end

   assign rsp_empty      = (ocnt_ff == '0);
   assign opop           = rsp_pop && !rsp_empty;
   assign rsp_out_bytes  = ofifo_ff[orptr_ff].bytes;
   assign rsp_byte_count = ofifo_ff[orptr_ff].count;
   assign rsp_burst_last = ofifo_ff[orptr_ff].last;

   always_comb begin
      owptr_in = opush ? owptr_ff + OUT_PTR_W'(1) : owptr_ff;
      orptr_in = opop ? orptr_ff + OUT_PTR_W'(1) : orptr_ff;
      ocnt_in  = ocnt_ff + (OUT_PTR_W+1)'(opush) - (OUT_PTR_W+1)'(opop);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BS_IDLE: begin
            if (!cmd_empty) begin
               case (cmd_data.kind)
                  CMD_START: state_in = BS_START;
                  CMD_RUN:   state_in = BS_HEAD;
                  default:   state_in = BS_FLUSH;
               endcase
            end
         end
         BS_START: if (byte_ready) state_in = BS_IDLE;
         BS_HEAD: begin
            if (byte_ready) begin
               if (min_nz) state_in = BS_MIN0;
               else if (cur_ff.width != '0) state_in = BS_READ;
               else state_in = BS_IDLE;
            end
         end
         BS_MIN0: begin
            if (byte_ready) begin
               if (extra_ff > 3'd1) state_in = BS_MINX;
               else if (cur_ff.width != '0) state_in = BS_READ;
               else state_in = BS_IDLE;
            end
         end
         BS_MINX: begin
            if (byte_ready && (extra_ff == 3'd1)) begin
               state_in = (cur_ff.width != '0) ? BS_READ : BS_IDLE;
            end
         end
         BS_READ:  state_in = BS_SUB;
         BS_SUB:   state_in = BS_MERGE;
         BS_MERGE: state_in = BS_EMIT;
         BS_EMIT: begin
            if (nacc_ff < NACC_W'(8)) begin
               if (idx_ff != total) state_in = BS_READ;
               else if (nacc_ff != '0) state_in = BS_PAD;
               else state_in = BS_FREE;
            end
         end
         BS_PAD:   if (byte_ready) state_in = BS_FREE;
         BS_FREE:  state_in = BS_IDLE;
         BS_FLUSH: if (flush_ready) state_in = BS_IDLE;
         default:  state_in = BS_IDLE;
      endcase
   end

   always_comb begin
      cur_in     = cur_ff;
      sign_in    = sign_ff;
      nib_in     = nib_ff;
      hi_in      = hi_ff;
      extra_in   = extra_ff;
      idx_in     = idx_ff;
      resid_in   = resid_ff;
      acc_in     = acc_ff;
      nacc_in    = nacc_ff;
      cmd_pop    = 1'b0;
      byte_valid = 1'b0;
      byte_data  = '0;
      flush_req  = 1'b0;
      free       = '0;
      case (state_ff)
         BS_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               cur_in   = cmd_data;
               sign_in  = cmd_data.minimum[SAMPLE_W-1];
               nib_in   = cmag[3:0];
               hi_in    = chi;
               extra_in = cextra;
               idx_in   = '0;
               acc_in   = '0;
               nacc_in  = '0;
            end
         end
         BS_START: begin
            byte_valid = 1'b1;
            byte_data  = START_BYTE;
         end
         BS_HEAD: begin
            byte_valid = 1'b1;
            byte_data  = header_byte(cur_ff.width, cur_ff.blocks) | (min_nz ? MIN_FLAG : 8'h00);
         end
         BS_MIN0: begin
            byte_valid = 1'b1;
            byte_data  = {sign_ff, nib_ff, extra_ff};
            if (byte_ready) extra_in = extra_ff - 3'd1;
         end
         BS_MINX: begin
            byte_valid = 1'b1;
            byte_data  = hi_ff[7:0];
            if (byte_ready) begin
               hi_in    = hi_ff >> 8;
               extra_in = extra_ff - 3'd1;
            end
         end
         BS_SUB: begin
            resid_in = (ram_rdata - cur_ff.minimum) & mask;
            idx_in   = idx_ff + TOTAL_W'(1);
         end
         BS_MERGE: begin
            acc_in  = ACC_W'(acc_ff << cur_ff.width) | ACC_W'(resid_ff);
            nacc_in = nacc_ff + NACC_W'(cur_ff.width);
         end
         BS_EMIT: begin
            if (nacc_ff >= NACC_W'(8)) begin
               byte_valid = 1'b1;
               byte_data  = 8'(acc_ff >> (nacc_ff - NACC_W'(8)));
               if (byte_ready) nacc_in = nacc_ff - NACC_W'(8);
            end
         end
         BS_PAD: begin
            byte_valid = 1'b1;
            byte_data  = 8'(acc_ff << (NACC_W'(8) - nacc_ff));
         end
         BS_FREE: begin
            free.valid = 1'b1;
            free.count = USED_W'(total);
         end
         BS_FLUSH: flush_req = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BS_IDLE;
         pcnt_ff  <= '0;
         owptr_ff <= '0;
         orptr_ff <= '0;
         ocnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pcnt_ff  <= pcnt_in;
         owptr_ff <= owptr_in;
         orptr_ff <= orptr_in;
         ocnt_ff  <= ocnt_in;
      end
      cur_ff   <= cur_in;
      sign_ff  <= sign_in;
      nib_ff   <= nib_in;
      hi_ff    <= hi_in;
      extra_ff <= extra_in;
      idx_ff   <= idx_in;
      resid_ff <= resid_in;
      acc_ff   <= acc_in;
      nacc_ff  <= nacc_in;
      word_ff  <= word_in;
      if (opush) ofifo_ff[owptr_ff] <= opush_data;
   end

endmodule

@@ design/block_offset_bitpack_compressor_core.sv @@
// Top level of the block offset bit-pack compressor: front, command queue, ring store, back.
// Samples enter one per cycle while a block fills; the sixteenth sample of a block, the first
// sample of a stream and the final sample each hold the input while the block's width is found
// and its commands are queued. Samples wait in a 512-word ring store until their run has been
// emitted (zero-width and dropped blocks leave at once); the input reports full when that ring
// is occupied. The back takes one command at a time and writes its bytes into a word packer
// that waits while the output queue is full; each residual is read, offset by the minimum,
// merged and cut into bytes. Words leave through a four-deep output queue, one per pop.
module block_offset_bitpack_compressor_core import bobc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_final_sample,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [31:0]                rsp_out_bytes,
   output logic [2:0]                 rsp_byte_count,
   output logic                       rsp_burst_last
);

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [SAMPLE_W-1:0] ram_wdata;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [SAMPLE_W-1:0] ram_rdata;
   logic                q_push;
   cmd_type             q_push_data;
   logic                q_full;
   logic                q_pop;
   cmd_type             q_pop_data;
   logic                q_empty;
   free_type            free;

   bobc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_sample       (req_sample),
      .req_final_sample (req_final_sample),
      .ram_we           (ram_we),
      .ram_waddr        (ram_waddr),
      .ram_wdata        (ram_wdata),
      .cmd_push         (q_push),
      .cmd_data         (q_push_data),
      .cmd_full         (q_full),
      .free             (free)
   );

   bobc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (RUN_STORE_DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   bobc_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   bobc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_empty      (q_empty),
      .cmd_data       (q_pop_data),
      .cmd_pop        (q_pop),
      .ram_raddr      (ram_raddr),
      .ram_rdata      (ram_rdata),
      .free           (free),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_bytes  (rsp_out_bytes),
      .rsp_byte_count (rsp_byte_count),
      .rsp_burst_last (rsp_burst_last)
   );

endmodule

@@ test/block_offset_bitpack_compressor_core_test.sv @@
// Self-checking testbench of the block offset bit-pack compressor core.
module block_offset_bitpack_compressor_core_test;
   import bobc_pkg::*;

   typedef struct {
      logic [31:0] bytes;
      logic [2:0]  count;
      logic        last;
   } stream_word_type;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 200;

   logic                       clock;
   logic                       reset;
   logic                       req_push;
   logic                       req_full;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       req_final_sample;
   logic                       rsp_empty;
   logic                       rsp_pop;
   logic [31:0]                rsp_out_bytes;
   logic [2:0]                 rsp_byte_count;
   logic                       rsp_burst_last;

   block_offset_bitpack_compressor_core DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_sample(req_sample), .req_final_sample(req_final_sample),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_out_bytes(rsp_out_bytes), .rsp_byte_count(rsp_byte_count),
      .rsp_burst_last(rsp_burst_last)
   );

   // Predictor state.
   logic signed [SAMPLE_W-1:0] blk_samples[BLOCK_LEN];
   logic [SAMPLE_W-1:0]        run_store[RUN_STORE_DEPTH];
   int                         blk_fill;
   logic signed [SAMPLE_W-1:0] blk_min, blk_max, run_min;
   int                         run_w, run_cnt;
   bit                         run_is_open, started;
   logic [7:0]                 pending_bytes[$];

   stream_word_type expected_words[$];
   int  errors;
   int  cycles;
   bit  quiet;
   int  hold_off;
   int  pop_stall;

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   function automatic int width_class_limit(input int w);
      if (w == 0) return 32;
      if (w <= 2) return 16;
      if (w <= 6) return 8;
      return 1;
   endfunction

   function automatic void emit_open_run();
      int h, cnt;
      longint m;
      logic [31:0] mag, hi;
      int extra;
      longint acc;
      int nacc;
      cnt = (run_cnt == 0) ? 0 : run_cnt - 1;
      if (run_w == 0) h = cnt * 4;
      else if (run_w <= 2) h = 1 + cnt * 4 + (run_w - 1) * 64;
      else if (run_w <= 6) h = 2 + cnt * 4 + (run_w - 3) * 32;
      else h = 3 + (run_w - 1) * 4;
      if (run_min == 0) begin
         pending_bytes.push_back(8'(h));
      end else begin
         m = run_min;
         mag = 32'(m < 0 ? -m : m);
         hi = mag >> 4;
         if (hi == 0) extra = 1;
         else if (hi <= 32'h0000_00FF) extra = 2;
         else if (hi <= 32'h0000_FFFF) extra = 3;
         else if (hi <= 32'h00FF_FFFF) extra = 4;
         else extra = 5;
         pending_bytes.push_back(8'(h) | MIN_FLAG);
         pending_bytes.push_back(8'(((mag & 32'hF) << 3) + (m < 0 ? 32'h80 : 32'h0) + extra));
         for (int i = 1; i < extra; i++) begin
            pending_bytes.push_back(hi[7:0]);
            hi = hi >> 8;
         end
      end
      if (run_w > 0) begin
         acc = 0;
         nacc = 0;
         for (int i = 0; i < run_cnt * BLOCK_LEN; i++) begin
            acc = (acc << run_w) | (longint'(run_store[i % RUN_STORE_DEPTH])
                                    & ((64'd1 << run_w) - 1));
            nacc += run_w;
            while (nacc >= 8) begin
               pending_bytes.push_back(8'(acc >> (nacc - 8)));
               nacc -= 8;
            end
            acc &= (64'd1 << nacc) - 1;
         end
         if (nacc > 0) pending_bytes.push_back(8'(acc << (8 - nacc)));
      end
   endfunction

   function automatic void add_block_to_run();
      if (run_w > 0) begin
         for (int i = 0; i < BLOCK_LEN; i++)
            run_store[(run_cnt * BLOCK_LEN + i) % RUN_STORE_DEPTH] =
               SAMPLE_W'(longint'(blk_samples[i]) - longint'(blk_min));
      end
      run_cnt++;
   endfunction

   function automatic void close_block();
      logic [SAMPLE_W-1:0] span;
      int w;
      span = SAMPLE_W'(longint'(blk_max) - longint'(blk_min));
      w = 0;
      for (int i = 0; i < SAMPLE_W; i++) if (span[i]) w = i + 1;
      if (run_is_open && w == run_w && blk_min == run_min && run_cnt < width_class_limit(w)) begin
         add_block_to_run();
         return;
      end
      if (run_is_open) emit_open_run();
      run_is_open = 1'b1;
      run_min = blk_min;
      run_w = w;
      run_cnt = 0;
      add_block_to_run();
   endfunction

   // Works out the stream words that one accepted sample causes.
   function automatic void predict_words(input logic signed [SAMPLE_W-1:0] s, input bit fin);
      stream_word_type w;
      int n;
      pending_bytes.delete();
      if (!started) begin
         pending_bytes.push_back(START_BYTE);
         started = 1'b1;
      end
      blk_samples[blk_fill] = s;
      if (blk_fill == 0) begin
         blk_min = s;
         blk_max = s;
      end else begin
         if (s < blk_min) blk_min = s;
         if (s > blk_max) blk_max = s;
      end
      if (blk_fill >= BLOCK_LEN - 1) begin
         close_block();
         blk_fill = 0;
      end else begin
         blk_fill++;
      end
      if (fin) begin
         if (run_is_open) emit_open_run();
         run_is_open = 1'b0;
         run_cnt = 0;
         blk_fill = 0;
         started = 1'b0;
      end
      n = (pending_bytes.size() + 3) / 4;
      for (int k = 0; k < n; k++) begin
         w.bytes = '0;
         w.count = 3'((pending_bytes.size() - k * 4 > 4) ? 4 : pending_bytes.size() - k * 4);
         for (int j = 0; j < w.count; j++) w.bytes[31 - 8 * j -: 8] = pending_bytes[k * 4 + j];
         w.last = (k + 1 == n);
         expected_words.push_back(w);
      end
   endfunction

   // Offers one sample and returns once it is accepted; push stays high unless a random pause drops it.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit fin);
      req_push <= 1'b1;
      req_sample <= s;
      req_final_sample <= fin;
      do @(posedge clock); while (req_full);
      predict_words(s, fin);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_push <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Sends one stream of blocks with a fixed minimum and width class.
   task automatic send_stream(input int blocks, input int w, input bit fin_at_end);
      longint lo, span, minimum, v;
      span = (w == 0) ? 0 : (64'd1 << w) - 1;
      lo = -(64'd1 << 30);
      minimum = lo + longint'($urandom_range(0, 32'((64'd1 << 31) - 1 - span)));
      if ($urandom_range(0, 2) == 0) minimum = longint'($urandom_range(0, 40)) - 20;
      if (minimum + span > (64'd1 << 30) - 1) minimum = (64'd1 << 30) - 1 - span;
      for (int b = 0; b < blocks; b++) begin
         for (int i = 0; i < BLOCK_LEN; i++) begin
            if (i == 0) v = minimum;
            else if (i == 1) v = minimum + span;
            else v = minimum + longint'($urandom_range(0, 32'(span)));
            send_sample(SAMPLE_W'(v), fin_at_end && b == blocks - 1 && i == BLOCK_LEN - 1);
         end
      end
   endtask

   task automatic test_directed();
      // Final with nothing open: only the start word comes out.
      send_sample('0, 1'b1);
      // Final on a partial block: the block is dropped.
      send_sample(SAMPLE_W'(5), 1'b0);
      send_sample(SAMPLE_W'(-7), 1'b0);
      send_sample(SAMPLE_W'(3), 1'b1);
      // Full-range block with final on its last sample.
      for (int i = 0; i < BLOCK_LEN; i++)
         send_sample(i[0] ? {1'b0, {(SAMPLE_W-1){1'b1}}} : {1'b1, {(SAMPLE_W-1){1'b0}}},
                     i == BLOCK_LEN - 1);
      wait_for_drain();
   endtask

   task automatic test_random_streams();
      int ws[8] = '{0, 1, 2, 3, 6, 7, 12, 31};
      int sent;
      sent = 0;
      while (sent < 32) begin
         automatic int w = ws[$urandom_range(0, 7)];
         automatic int nb = $urandom_range(1, 4);
         if ($urandom_range(0, 7) == 0) begin
            // Broken stream: a final in the middle of a block.
            repeat ($urandom_range(1, 14)) send_sample(SAMPLE_W'($urandom), 1'b0);
            send_sample(SAMPLE_W'($urandom), 1'b1);
            sent += 8;
         end else begin
            send_stream(nb, w, $urandom_range(0, 2) != 0);
            sent += nb * BLOCK_LEN;
         end
      end
      send_sample('0, 1'b1);
      wait_for_drain();
   endtask

   // Short wide streams queue commands quickly, so the input stalls while pops are held off.
   task automatic test_long_stall();
      hold_off = 6000;
      repeat (3) send_stream(1, 12, 1'b1);
      wait_for_drain();
   endtask

   // Nine blocks of one width class split into a full run and a single-block run.
   task automatic test_long_runs();
      quiet = 1'b1;
      send_stream(9, 3, 1'b1);
      wait_for_drain();
   endtask

   // Result side: random stall bursts and one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_pop <= 1'b0;
      end else if (pop_stall > 0) begin
         pop_stall <= pop_stall - 1;
         rsp_pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         pop_stall <= $urandom_range(0, 9);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   always @(posedge clock) begin
      stream_word_type w;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word %h", rsp_out_bytes);
            errors++;
         end else begin
            w = expected_words.pop_front();
            if (rsp_out_bytes !== w.bytes) begin
               $error("out_bytes expected %h actual %h", w.bytes, rsp_out_bytes);
               errors++;
            end
            if (rsp_byte_count !== w.count) begin
               $error("byte_count expected %0d actual %0d", w.count, rsp_byte_count);
               errors++;
            end
            if (rsp_burst_last !== w.last) begin
               $error("burst_last expected %0d actual %0d", w.last, rsp_burst_last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("block_offset_bitpack_compressor_core verification failed");
         $finish;
      end
   end

   initial begin
      errors = 0;
      cycles = 0;
      quiet = 1'b0;
      hold_off = 0;
      pop_stall = 0;
      blk_fill = 0;
      blk_min = '0;
      blk_max = '0;
      run_min = '0;
      run_w = 0;
      run_cnt = 0;
      run_is_open = 1'b0;
      started = 1'b0;
      reset = 1'b1;
      req_push = 1'b0;
      req_sample = '0;
      req_final_sample = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_streams();
      test_long_stall();
      test_long_runs();
      if (errors == 0 && expected_words.size() == 0) begin
         $display("block_offset_bitpack_compressor_core verification clean");
      end else begin
         $display("block_offset_bitpack_compressor_core verification failed");
      end
      $finish;
   end

endmodule
